// ===== sv/hrre_pkg.sv =====
// Package for the hit-ranked rule enforcer.
// Holds the rule entry type, the result word type and the sequencer states.
// No dependencies.
package hrre_pkg;

    localparam int MAX_RULES_DEF = 16;
    localparam int ID_W          = 8;
    localparam int RATE_W        = 32;
    localparam int LIM_W         = 5;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [RATE_W-1:0] rate;
        logic              act;
    } entry_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic             enforced;
        logic             last;
        logic [LIM_W-1:0] size;
    } emit_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_CMP,
        ST_INS,
        ST_EM_RD,
        ST_EM_CHK
    } state_t;

endpackage

// ===== sv/hit_ranked_rule_enforcer.sv =====
// Hit-ranked rule enforcer: insertion-sorts up to MAX_RULES rules by hit rate,
// then emits enforced active rules followed by the rest, one word per result.
// Loading: a rule is compared with stored entries in turn, shifting each one whose
// rate is not higher, until a higher one stops the scan; one shared compare unit and
// one memory port; rules arriving when full drop. Emission: two passes, output may stall.
// Input not ready meanwhile. Sync active-low reset clears control state and the limit.
module hit_ranked_rule_enforcer
    import hrre_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // rule_id[7:0], hit_rate[39:8], active[40], zero pad
    input  logic        s_tlast,   // last_rule
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // rule_id_res[7:0], enforced[8], reported_size[13:9], pad
    output logic        m_tlast,   // last_out
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata  // max_enforced
);

    logic [LIM_W-1:0] max_enf_reg;
    logic             m_valid_reg;
    logic [ID_W-1:0]  m_id_reg;
    logic             m_enf_reg;
    logic             m_last_reg;
    logic [LIM_W-1:0] m_size_reg;
    logic             out_free;
    entry_t           in_entry;
    emit_t            emit;

    assign in_entry.id   = s_tdata[7:0];
    assign in_entry.rate = s_tdata[39:8];
    assign in_entry.act  = s_tdata[40];
    assign out_free      = !m_valid_reg || m_tready;

    hrre_seq #(
        .MAX_RULES (MAX_RULES)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_entry     (in_entry),
        .in_last      (s_tlast),
        .max_enforced (max_enf_reg),
        .out_free     (out_free),
        .emit         (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_enf_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_enf_reg <= cfg_wdata;
            end
            if (emit.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_id_reg   <= emit.id;
            m_enf_reg  <= emit.enforced;
            m_last_reg <= emit.last;
            m_size_reg <= emit.size;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_size_reg, m_enf_reg, m_id_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> (!m_valid_reg || m_tready))
        else $error("result word overwritten while pending");

    a_size_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_size_reg == '0))
        else $error("reported size on non-final word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && s_tready))
        else $error("not idle after reset");

endmodule

// ===== sv/hrre_seq.sv =====
// Rule store and sequencer: insertion sort into the rule memory, then two
// emission passes (enforced, then the rest). Depends on hrre_pkg.
module hrre_seq
    import hrre_pkg::*;
#(
    parameter int  MAX_RULES = MAX_RULES_DEF,
    localparam int CW        = $clog2(MAX_RULES + 1),
    localparam int AW        = $clog2(MAX_RULES),
    localparam int SW        = (CW > LIM_W) ? CW : LIM_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  entry_t           in_entry,
    input  logic             in_last,
    input  logic [LIM_W-1:0] max_enforced,
    input  logic             out_free,
    output emit_t            emit
);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        ocnt_reg, ocnt_next;
    logic [LIM_W-1:0]     used_reg, used_next;
    logic                 pass_reg, pass_next;
    logic [MAX_RULES-1:0] taken_reg, taken_next;
    entry_t               new_reg;
    logic                 new_last_reg;
    entry_t               rd_data_reg;

    entry_t               mem [MAX_RULES];
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    entry_t               mem_wdata;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic [CW-1:0]        idx_dec;
    logic [CW-1:0]        cnt_dec;
    logic                 full;
    logic                 stop;
    logic                 want;
    logic                 at_end;
    logic [SW-1:0]        cnt_w;
    logic [SW-1:0]        lim_w;

    assign idx_dec = idx_reg - 1'b1;
    assign cnt_dec = count_reg - 1'b1;
    assign full    = (count_reg == CW'(MAX_RULES));
    assign stop    = (rd_data_reg.rate > new_reg.rate);
    assign want    = pass_reg ? !taken_reg[idx_reg[AW-1:0]]
                              : (rd_data_reg.act && (used_reg < max_enforced));
    assign at_end  = (idx_reg == cnt_dec);
    assign cnt_w   = SW'(count_reg);
    assign lim_w   = SW'(max_enforced);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (full) begin
                        state_next = in_last ? ST_EM_RD : ST_IDLE;
                    end else begin
                        state_next = (count_reg == '0) ? ST_INS : ST_SH_RD;
                    end
                end
            end
            ST_SH_RD:  state_next = ST_SH_CMP;
            ST_SH_CMP: state_next = (stop || idx_reg == CW'(1)) ? ST_INS : ST_SH_RD;
            ST_INS:    state_next = new_last_reg ? ST_EM_RD : ST_IDLE;
            ST_EM_RD:  state_next = ST_EM_CHK;
            ST_EM_CHK: begin
                if (!(want && !out_free)) begin
                    state_next = (at_end && pass_reg) ? ST_IDLE : ST_EM_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        ocnt_next  = ocnt_reg;
        used_next  = used_reg;
        pass_next  = pass_reg;
        taken_next = taken_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = new_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        emit       = '0;
        case (state_reg)
            ST_IDLE: begin
                idx_next   = full ? '0 : count_reg;
                pass_next  = 1'b0;
                used_next  = '0;
                ocnt_next  = '0;
                taken_next = '0;
            end
            ST_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[AW-1:0];
            end
            ST_SH_CMP: begin
                if (!stop) begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg;
                    idx_next  = idx_dec;
                end
            end
            ST_INS: begin
                mem_we     = 1'b1;
                count_next = count_reg + 1'b1;
                idx_next   = '0;
            end
            ST_EM_RD: begin
                rd_en = 1'b1;
            end
            ST_EM_CHK: begin
                if (!(want && !out_free)) begin
                    if (want) begin
                        emit.valid    = 1'b1;
                        emit.id       = rd_data_reg.id;
                        emit.enforced = !pass_reg;
                        emit.last     = (ocnt_reg == cnt_dec);
                        emit.size     = (ocnt_reg == cnt_dec)
                                      ? ((cnt_w < lim_w) ? LIM_W'(count_reg) : max_enforced)
                                      : '0;
                        ocnt_next     = ocnt_reg + 1'b1;
                        if (!pass_reg) begin
                            taken_next[idx_reg[AW-1:0]] = 1'b1;
                            used_next = used_reg + 1'b1;
                        end
                    end
                    if (at_end) begin
                        idx_next  = '0;
                        pass_next = 1'b1;
                        if (pass_reg) begin
                            count_next = '0;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            ocnt_reg  <= '0;
            used_reg  <= '0;
            pass_reg  <= 1'b0;
            taken_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ocnt_reg  <= ocnt_next;
            used_reg  <= used_next;
            pass_reg  <= pass_next;
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_valid) begin
            new_reg      <= in_entry;
            new_last_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count above capacity");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EM_CHK || state_reg == ST_EM_RD) |->
        (count_reg != '0 && idx_reg < count_reg))
        else $error("emission index out of range");

    a_used_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid && emit.enforced |-> used_reg < max_enforced)
        else $error("enforced beyond limit");

endmodule
